// ===== design/mdfc_pkg.sv =====
package mdfc_pkg;

  // Default ring depth and the fixed field widths.
  localparam int unsigned ID_SLOTS_DEF = 16;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LBIT_W       = 3;
  localparam int unsigned CLASS_W      = 3;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  // Services above this code are external.
  localparam logic [BYTE_W-1:0] EXT_SERVICE_FLOOR = 8'd16;

  // Input command codes.
  localparam logic CMD_RECEIVE  = 1'b0;
  localparam logic CMD_OWN_SEND = 1'b1;

  // Packet classes.
  localparam logic [CLASS_W-1:0] CLASS_NONE      = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_TEXT      = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_COMMAND   = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_HEARTBEAT = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_EXTERNAL  = 3'd4;

  // Destination kinds.
  localparam logic [KIND_W-1:0] KIND_DIRECT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BROADCAST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOCAL     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_BIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_SVC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_SVC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HBEAT_SVC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_HBEAT = 3'd6;

  // Register reset values.
  localparam logic [ADDR_W-1:0] BCAST_ADDR_RST = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST   = 32'h0000_0000;
  localparam logic [LBIT_W-1:0] LOCAL_BIT_RST  = 3'd7;
  localparam logic [BYTE_W-1:0] TEXT_SVC_RST   = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_SVC_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] HBEAT_SVC_RST  = 8'd2;
  localparam logic              SHOW_HBEAT_RST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

endpackage

// ===== design/mdfc_if.sv =====
interface mdfc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [mdfc_pkg::ID_W-1:0]     packet_id;
  logic [mdfc_pkg::ADDR_W-1:0]   dest_address;
  logic [mdfc_pkg::BYTE_W-1:0]   flag_bits;
  logic [mdfc_pkg::BYTE_W-1:0]   service_code;

  modport source (output valid, cmd, packet_id, dest_address, flag_bits, service_code,
                  input ready);
  modport sink   (input valid, cmd, packet_id, dest_address, flag_bits, service_code,
                  output ready);
endinterface

interface mdfc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          duplicate;
  logic                          reflood;
  logic [mdfc_pkg::CLASS_W-1:0]  packet_class;
  logic [mdfc_pkg::KIND_W-1:0]   dest_kind;
  logic                          self_reject;

  modport source (output valid, duplicate, reflood, packet_class, dest_kind, self_reject,
                  input ready);
  modport sink   (input valid, duplicate, reflood, packet_class, dest_kind, self_reject,
                  output ready);
endinterface

interface mdfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mdfc_pkg::CFG_IDX_W-1:0]   index;
  logic [mdfc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mesh_duplicate_filter_classifier.sv =====
// Received header, new identifier: the scan compares one ring slot per cycle over the
// whole ring, then a write state stores the identifier and a result state loads the result.
// A duplicate ends the scan at the matching slot and skips the write; an own-send item
// skips the scan. Input ready returns the cycle after the result loads, so the block takes
// one item at a time; the load waits while an unaccepted result holds the result register.
// Reset (asynchronous, active low) empties the ring, zeroes the write pointer and loads defaults.
module mesh_duplicate_filter_classifier #(
  parameter int unsigned ID_SLOTS = mdfc_pkg::ID_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdfc_in_if.sink     in_i,
  mdfc_out_if.source  out_o,
  mdfc_cfg_if.sink    cfg_i
);
  import mdfc_pkg::*;

  localparam int unsigned AW = $clog2(ID_SLOTS);
  localparam int unsigned CW = $clog2(ID_SLOTS + 1);

  state_e state_q, state_d;

  // Configuration registers.
  logic [ADDR_W-1:0] bcast_addr_q, own_addr_q;
  logic [LBIT_W-1:0] local_bit_q;
  logic [BYTE_W-1:0] text_svc_q, cmd_svc_q, hbeat_svc_q;
  logic              show_hbeat_q;

  // Item held while in work.
  logic              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [ADDR_W-1:0] dest_q;
  logic [BYTE_W-1:0] flags_q, svc_q;
  logic              dup_q, dup_d;

  // Ring storage.
  logic [ID_W-1:0]     ring_mem [ID_SLOTS];
  logic [ID_SLOTS-1:0] slot_valid_q;
  logic [AW-1:0]       slot_q, slot_next;
  logic [CW-1:0]       scan_cnt_q, scan_cnt_d;
  logic [AW-1:0]       rd_addr;
  logic [ID_W-1:0]     rd_data_q;
  logic                rd_valid_q;
  logic                hit;
  logic                ring_we;

  // Result register.
  logic              out_valid_q;
  logic              out_dup_q, out_reflood_q, out_rej_q;
  logic [CLASS_W-1:0] out_class_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic              out_free, out_load;
  logic              res_reflood, res_rej;
  logic [CLASS_W-1:0] res_class;
  logic [KIND_W-1:0]  res_kind;
  logic              is_local, is_bcast;

  logic in_xfer;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcast_addr_q <= BCAST_ADDR_RST;
      own_addr_q   <= OWN_ADDR_RST;
      local_bit_q  <= LOCAL_BIT_RST;
      text_svc_q   <= TEXT_SVC_RST;
      cmd_svc_q    <= CMD_SVC_RST;
      hbeat_svc_q  <= HBEAT_SVC_RST;
      show_hbeat_q <= SHOW_HBEAT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BCAST_ADDR: bcast_addr_q <= cfg_i.data;
        REG_OWN_ADDR:   own_addr_q   <= cfg_i.data;
        REG_LOCAL_BIT:  local_bit_q  <= cfg_i.data[LBIT_W-1:0];
        REG_TEXT_SVC:   text_svc_q   <= cfg_i.data[BYTE_W-1:0];
        REG_CMD_SVC:    cmd_svc_q    <= cfg_i.data[BYTE_W-1:0];
        REG_HBEAT_SVC:  hbeat_svc_q  <= cfg_i.data[BYTE_W-1:0];
        REG_SHOW_HBEAT: show_hbeat_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= in_i.cmd;
      id_q    <= in_i.packet_id;
      dest_q  <= in_i.dest_address;
      flags_q <= in_i.flag_bits;
      svc_q   <= in_i.service_code;
    end
  end

  // The scan reads one slot per cycle; the compare works on the slot read the cycle before.
  assign rd_addr = scan_cnt_q[AW-1:0];
  assign hit     = (scan_cnt_q != '0) &&
                   ((rd_valid_q ? rd_data_q : '0) == id_q);

  // The pointer advances before the write, so the first write lands in slot 1.
  assign slot_next = (slot_q == AW'(ID_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign ring_we   = (state_q == ST_WRITE);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_next] <= id_q;
    end
    rd_data_q  <= ring_mem[rd_addr];
    rd_valid_q <= slot_valid_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      slot_q       <= '0;
    end else if (ring_we) begin
      slot_valid_q[slot_next] <= 1'b1;
      slot_q                  <= slot_next;
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    dup_d      = dup_q;
    case (state_q)
      ST_IDLE: begin
        scan_cnt_d = '0;
        dup_d      = 1'b0;
        if (in_xfer) begin
          state_d = (in_i.cmd == CMD_OWN_SEND) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          dup_d   = 1'b1;
          state_d = ST_OUT;
        end else if (scan_cnt_q == CW'(ID_SLOTS)) begin
          state_d = ST_WRITE;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      ST_WRITE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      dup_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      dup_q      <= dup_d;
    end
  end

  // Result fields from the held item.
  assign is_local = flags_q[local_bit_q];
  assign is_bcast = (dest_q == bcast_addr_q);

  always_comb begin
    res_reflood = 1'b0;
    res_class   = CLASS_NONE;
    res_kind    = KIND_DIRECT;
    res_rej     = 1'b0;
    if (cmd_q == CMD_OWN_SEND) begin
      res_rej = (dest_q == own_addr_q);
    end else if (!dup_q) begin
      res_reflood = is_bcast && !is_local;
      if (is_bcast) begin
        res_kind = is_local ? KIND_LOCAL : KIND_BROADCAST;
      end
      if (svc_q == text_svc_q) begin
        res_class = CLASS_TEXT;
      end else if (svc_q == cmd_svc_q) begin
        res_class = CLASS_COMMAND;
      end else if (svc_q == hbeat_svc_q && show_hbeat_q) begin
        res_class = CLASS_HEARTBEAT;
      end else if (svc_q > EXT_SERVICE_FLOOR) begin
        res_class = CLASS_EXTERNAL;
      end
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == ST_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dup_q     <= dup_q;
      out_reflood_q <= res_reflood;
      out_class_q   <= res_class;
      out_kind_q    <= res_kind;
      out_rej_q     <= res_rej;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.duplicate    = out_dup_q;
  assign out_o.reflood      = out_reflood_q;
  assign out_o.packet_class = out_class_q;
  assign out_o.dest_kind    = out_kind_q;
  assign out_o.self_reject  = out_rej_q;

endmodule

// ===== design/mdfc_checker.sv =====
module mdfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            duplicate,
  input logic                            reflood,
  input logic [mdfc_pkg::CLASS_W-1:0]    packet_class,
  input logic [mdfc_pkg::KIND_W-1:0]     dest_kind,
  input logic                            self_reject
);
  import mdfc_pkg::*;

  // The block works on one item at a time, so it is busy right after a transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A dropped duplicate carries no classification.
  a_dup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && duplicate |-> !reflood && !self_reject &&
      packet_class == CLASS_NONE && dest_kind == KIND_DIRECT)
    else $error("duplicate result with other fields set");

  // A self reject only comes from an own send, which is never classified.
  a_rej_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && self_reject |-> !duplicate && !reflood &&
      packet_class == CLASS_NONE && dest_kind == KIND_DIRECT)
    else $error("self reject with receive fields set");

  a_reflood_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && reflood |-> dest_kind == KIND_BROADCAST)
    else $error("reflood without a plain broadcast destination");

endmodule

bind mesh_duplicate_filter_classifier mdfc_checker u_mdfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .duplicate    (out_o.duplicate),
  .reflood      (out_o.reflood),
  .packet_class (out_o.packet_class),
  .dest_kind    (out_o.dest_kind),
  .self_reject  (out_o.self_reject)
);

// ===== tb/mdfc_tb_pkg.sv =====
`timescale 1ns / 100ps

package mdfc_tb_pkg;
  import mdfc_pkg::*;

  localparam int unsigned RING_DEPTH = ID_SLOTS_DEF;
  localparam int unsigned PRINT_CAP  = 100;

  typedef struct packed {
    logic               duplicate;
    logic               reflood;
    logic [CLASS_W-1:0] packet_class;
    logic [KIND_W-1:0]  dest_kind;
    logic               self_reject;
  } verdict_t;

  class packet_verdict_board;
    logic [ID_W-1:0]   seen_ring [RING_DEPTH];
    int unsigned       ring_slot;
    logic [ADDR_W-1:0] bcast_addr;
    logic [ADDR_W-1:0] own_addr;
    logic [LBIT_W-1:0] local_bit;
    logic [BYTE_W-1:0] text_svc;
    logic [BYTE_W-1:0] cmd_svc;
    logic [BYTE_W-1:0] hbeat_svc;
    logic              show_hbeat;
    verdict_t          verdicts_due [$];
    int unsigned       mismatch_count;
    int unsigned       checked_count;
    int unsigned       dup_count;

    function new();
      foreach (seen_ring[i]) seen_ring[i] = '0;
      ring_slot      = 0;
      bcast_addr     = BCAST_ADDR_RST;
      own_addr       = OWN_ADDR_RST;
      local_bit      = LOCAL_BIT_RST;
      text_svc       = TEXT_SVC_RST;
      cmd_svc        = CMD_SVC_RST;
      hbeat_svc      = HBEAT_SVC_RST;
      show_hbeat     = SHOW_HBEAT_RST;
      mismatch_count = 0;
      checked_count  = 0;
      dup_count      = 0;
    endfunction

    // Unknown indexes are dropped and only the low bits of each register are kept.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BCAST_ADDR: bcast_addr = data[ADDR_W-1:0];
        REG_OWN_ADDR:   own_addr   = data[ADDR_W-1:0];
        REG_LOCAL_BIT:  local_bit  = data[LBIT_W-1:0];
        REG_TEXT_SVC:   text_svc   = data[BYTE_W-1:0];
        REG_CMD_SVC:    cmd_svc    = data[BYTE_W-1:0];
        REG_HBEAT_SVC:  hbeat_svc  = data[BYTE_W-1:0];
        REG_SHOW_HBEAT: show_hbeat = data[0];
        default: ;
      endcase
    endfunction

    // The pointer moves first, so slot 1 takes the first identifier after reset.
    function void record_id(logic [ID_W-1:0] id);
      ring_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
      seen_ring[ring_slot] = id;
    endfunction

    function bit ring_has(logic [ID_W-1:0] id);
      foreach (seen_ring[i]) begin
        if (seen_ring[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_packet(logic cmd, logic [ID_W-1:0] id, logic [ADDR_W-1:0] dest,
                              logic [BYTE_W-1:0] flags, logic [BYTE_W-1:0] svc);
      verdict_t v;
      logic     is_local;
      logic     is_bcast;
      v = '0;
      if (cmd == CMD_OWN_SEND) begin
        record_id(id);
        v.self_reject = (dest == own_addr);
      end else if (ring_has(id)) begin
        v.duplicate = 1'b1;
        dup_count++;
      end else begin
        is_local = flags[local_bit];
        is_bcast = (dest == bcast_addr);
        record_id(id);
        v.reflood = is_bcast && !is_local;
        if (!is_bcast) v.dest_kind = KIND_DIRECT;
        else if (is_local) v.dest_kind = KIND_LOCAL;
        else v.dest_kind = KIND_BROADCAST;
        if (svc == text_svc) v.packet_class = CLASS_TEXT;
        else if (svc == cmd_svc) v.packet_class = CLASS_COMMAND;
        else if (svc == hbeat_svc && show_hbeat) v.packet_class = CLASS_HEARTBEAT;
        else if (svc > EXT_SERVICE_FLOOR) v.packet_class = CLASS_EXTERNAL;
        else v.packet_class = CLASS_NONE;
      end
      verdicts_due.push_back(v);
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                  checked_count, name, got, want));
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result transfer with no packet pending (%0h)", got));
      end else begin
        want = verdicts_due.pop_front();
        compare_field("duplicate", got.duplicate, want.duplicate);
        compare_field("reflood", got.reflood, want.reflood);
        compare_field("packet_class", got.packet_class, want.packet_class);
        compare_field("dest_kind", got.dest_kind, want.dest_kind);
        compare_field("self_reject", got.self_reject, want.self_reject);
      end
      checked_count++;
    endtask
  endclass

endpackage

// ===== tb/tb_mesh_duplicate_filter_classifier.sv =====
`timescale 1ns / 100ps

module tb_mesh_duplicate_filter_classifier;
  import mdfc_pkg::*;
  import mdfc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned RECENT_DEPTH = 24;
  localparam int unsigned MAX_IDLE     = 13;
  localparam int unsigned TAIL_CYCLES  = 40;

  // An index past the last register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;

  mdfc_in_if  in_bus ();
  mdfc_out_if out_bus ();
  mdfc_cfg_if cfg_bus ();

  mesh_duplicate_filter_classifier dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  packet_verdict_board board;
  bit                  quiet_mode = 1'b0;
  logic [ID_W-1:0]     recent_ids [$];
  int unsigned         items_sent = 0;
  int unsigned         own_sends  = 0;
  int unsigned         cfg_writes = 0;
  int unsigned         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, board.verdicts_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Result side: random stalls, then check each transfer against the oldest prediction.
  initial begin : result_sink
    verdict_t    got;
    int unsigned stall;
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.duplicate    = out_bus.duplicate;
      got.reflood      = out_bus.reflood;
      got.packet_class = out_bus.packet_class;
      got.dest_kind    = out_bus.dest_kind;
      got.self_reject  = out_bus.self_reject;
      board.check_verdict(got);
    end
  end

  // Leaves valid high after the transfer so back-to-back items need no second assignment.
  task automatic send_packet(logic cmd, logic [ID_W-1:0] id, logic [ADDR_W-1:0] dest,
                             logic [BYTE_W-1:0] flags, logic [BYTE_W-1:0] svc);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= cmd;
    in_bus.packet_id    <= id;
    in_bus.dest_address <= dest;
    in_bus.flag_bits    <= flags;
    in_bus.service_code <= svc;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    board.note_packet(cmd, id, dest, flags, svc);
    items_sent++;
    if (cmd == CMD_OWN_SEND) own_sends++;
    recent_ids.push_back(id);
    if (recent_ids.size() > RECENT_DEPTH) void'(recent_ids.pop_front());
  endtask

  task automatic wait_results();
    in_bus.valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    board.write_reg(idx, data);
    cfg_writes++;
  endtask

  // Full 32-bit data goes to every register; the narrow ones must drop the upper bits.
  task automatic load_settings(logic [31:0] bcast, logic [31:0] own, logic [31:0] lbit,
                               logic [31:0] text, logic [31:0] cmd, logic [31:0] hbeat,
                               logic [31:0] show);
    write_reg(REG_BCAST_ADDR, bcast);
    write_reg(REG_OWN_ADDR, own);
    write_reg(REG_LOCAL_BIT, lbit);
    write_reg(REG_TEXT_SVC, text);
    write_reg(REG_CMD_SVC, cmd);
    write_reg(REG_HBEAT_SVC, hbeat);
    write_reg(REG_SHOW_HBEAT, show);
    // This index is not a register; the write must change nothing.
    write_reg(REG_UNUSED, $urandom);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_random_packet();
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] dest;
    logic [BYTE_W-1:0] svc;
    logic [BYTE_W-1:0] flags;
    int unsigned       r;
    cmd = ($urandom_range(0, 3) == 0) ? CMD_OWN_SEND : CMD_RECEIVE;
    r = $urandom_range(0, 99);
    if (r < 40 && recent_ids.size() > 0) id = recent_ids[$urandom_range(0, recent_ids.size()-1)];
    else if (r < 48) id = '0;
    else if (r < 52) id = '1;
    else id = $urandom;
    r = $urandom_range(0, 99);
    if (r < 30) dest = board.bcast_addr;
    else if (r < 45) dest = board.own_addr;
    else if (r < 50) dest = '0;
    else if (r < 55) dest = '1;
    else dest = $urandom;
    r = $urandom_range(0, 99);
    if (r < 15) svc = board.text_svc;
    else if (r < 30) svc = board.cmd_svc;
    else if (r < 45) svc = board.hbeat_svc;
    else if (r < 50) svc = EXT_SERVICE_FLOOR;
    else if (r < 55) svc = EXT_SERVICE_FLOOR + 8'd1;
    else if (r < 60) svc = 8'h00;
    else if (r < 65) svc = 8'hFF;
    else svc = BYTE_W'($urandom_range(0, 255));
    flags = BYTE_W'($urandom_range(0, 255));
    send_packet(cmd, id, dest, flags, svc);
  endtask

  initial begin : stimulus
    board = new();
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.cmd          <= CMD_RECEIVE;
    in_bus.packet_id    <= '0;
    in_bus.dest_address <= '0;
    in_bus.flag_bits    <= '0;
    in_bus.service_code <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults. The ring starts all zero, so identifier 0 is already seen.
    send_packet(CMD_RECEIVE, 32'h0, 32'hFFFF_FFFF, 8'h00, 8'd0);
    send_packet(CMD_RECEIVE, 32'h1, 32'hFFFF_FFFF, 8'h00, 8'd0);
    send_packet(CMD_RECEIVE, 32'h1, 32'hFFFF_FFFF, 8'h00, 8'd0);
    send_packet(CMD_RECEIVE, 32'h2, 32'hFFFF_FFFF, 8'h80, 8'd1);
    send_packet(CMD_RECEIVE, 32'h3, 32'h0000_0005, 8'h7F, 8'd2);
    send_packet(CMD_RECEIVE, 32'hFFFF_FFFF, 32'h0, 8'hFF, 8'd16);
    send_packet(CMD_RECEIVE, 32'h4, 32'hFFFF_FFFE, 8'h00, 8'd17);
    send_packet(CMD_RECEIVE, 32'h5A5A_A5A5, 32'h8000_0000, 8'h55, 8'd255);
    send_packet(CMD_OWN_SEND, 32'h5, 32'h0, 8'hFF, 8'hFF);
    send_packet(CMD_OWN_SEND, 32'h6, 32'hFFFF_FFFF, 8'h00, 8'h00);
    send_packet(CMD_RECEIVE, 32'h5, 32'hFFFF_FFFF, 8'h00, 8'd0);
    // An own send records its identifier even when it is already in the ring.
    send_packet(CMD_OWN_SEND, 32'h5, 32'h0, 8'h00, 8'd0);
    send_packet(CMD_RECEIVE, 32'h6, 32'h1234_5678, 8'h00, 8'd3);
    wait_results();

    // Heartbeats off, text and command sharing a code, local flag on bit 0.
    load_settings(32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFF8, 32'd3, 32'd3, 32'd20, 32'h2);
    send_packet(CMD_RECEIVE, 32'h10, 32'h0, 8'h00, 8'd20);
    send_packet(CMD_RECEIVE, 32'h11, 32'h0, 8'h00, 8'd3);
    send_packet(CMD_RECEIVE, 32'h12, 32'hFFFF_FFFF, 8'h01, 8'd2);
    send_packet(CMD_OWN_SEND, 32'h13, 32'h1234_5678, 8'h00, 8'd0);
    send_packet(CMD_RECEIVE, 32'h13, 32'h1234_5678, 8'h00, 8'd0);
    wait_results();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(32'hFFFF_FFFF, 32'h0, 32'h0, 32'd0, 32'd1, 32'd2, 32'h1);
        1: load_settings(32'h0, 32'hFFFF_FFFF, 32'h7, 32'd255, 32'd0, 32'd16, 32'h0);
        3: load_settings($urandom, $urandom, 32'hFFFF_FFF8, 32'd17, 32'd17, 32'd17, 32'h1);
        4: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3, 32'd16, 32'd255, 32'd0,
                         32'hFFFF_FFFE);
        default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
      endcase
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        quiet_mode = (p == 2) || (p == 5) || (i >= 80 && i < 120);
        send_random_packet();
        // Hold the sender off mid-phase until every result is back.
        if (i == PHASE_ITEMS / 2) wait_results();
      end
      wait_results();
    end

    quiet_mode = 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.verdicts_due.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived",
                                      board.verdicts_due.size()));

    $display("Sent %0d packets (%0d own sends, %0d predicted duplicates), %0d results checked",
             items_sent, own_sends, board.dup_count, board.checked_count);
    $display("Register writes: %0d over %0d settings, %0d mismatches",
             cfg_writes, PHASES + 1, board.mismatch_count);
    if (board.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mdfc_pkg.sv
design/mdfc_if.sv
design/mesh_duplicate_filter_classifier.sv
design/mdfc_checker.sv
tb/mdfc_tb_pkg.sv
tb/tb_mesh_duplicate_filter_classifier.sv
